// ===== rtl/lcdm_pkg.sv =====
// lcdm_pkg: widths, constants and control structs shared by the
// lagged cross displacement mean block and its submodules
// no dependencies
package lcdm_pkg;

    localparam int MAX_SAMPLES = 64;
    localparam int ADDR_W      = $clog2(MAX_SAMPLES);
    localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);

    localparam int SAMPLE_W    = 24;
    localparam int DIFF_W      = SAMPLE_W + 1;
    localparam int PROD_W      = 2 * DIFF_W;
    localparam int SUM_W       = 56;
    localparam int LAG_W       = 6;

    localparam int DIV_STEPS   = SUM_W;
    localparam int STEP_W      = $clog2(DIV_STEPS);
    localparam int DIVISOR_W   = CNT_W;

    localparam int S_TDATA_W   = 2 * SAMPLE_W;
    localparam int M_TDATA_W   = ((LAG_W + SUM_W + 7) / 8) * 8;
    localparam int M_PAD_W     = M_TDATA_W - LAG_W - SUM_W;

    typedef struct packed {
        logic clr;
        logic issue;
    } mac_ctl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

// ===== rtl/lcdm_store.sv =====
// lcdm_store: x and y sample memories, one write port and two
// registered read ports each
// depends on lcdm_pkg
module lcdm_store (
    input  logic                                  aclk,
    input  logic                                  wr_en,
    input  logic [lcdm_pkg::ADDR_W-1:0]           wr_addr,
    input  logic signed [lcdm_pkg::SAMPLE_W-1:0]  wr_x,
    input  logic signed [lcdm_pkg::SAMPLE_W-1:0]  wr_y,
    input  logic [lcdm_pkg::ADDR_W-1:0]           rd_addr_a,
    input  logic [lcdm_pkg::ADDR_W-1:0]           rd_addr_b,
    output logic signed [lcdm_pkg::SAMPLE_W-1:0]  x_a,
    output logic signed [lcdm_pkg::SAMPLE_W-1:0]  x_b,
    output logic signed [lcdm_pkg::SAMPLE_W-1:0]  y_a,
    output logic signed [lcdm_pkg::SAMPLE_W-1:0]  y_b
);

    logic signed [lcdm_pkg::SAMPLE_W-1:0] x_mem [lcdm_pkg::MAX_SAMPLES];
    logic signed [lcdm_pkg::SAMPLE_W-1:0] y_mem [lcdm_pkg::MAX_SAMPLES];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            x_mem[wr_addr] <= wr_x;
            y_mem[wr_addr] <= wr_y;
        end
    end

    always_ff @(posedge aclk) begin
        x_a <= x_mem[rd_addr_a];
        x_b <= x_mem[rd_addr_b];
        y_a <= y_mem[rd_addr_a];
        y_b <= y_mem[rd_addr_b];
    end

endmodule

// ===== rtl/lcdm_mac.sv =====
// lcdm_mac: difference, multiply and accumulate pipeline shared by all
// pairs of one lag
// depends on lcdm_pkg
module lcdm_mac (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  lcdm_pkg::mac_ctl_t                    ctl,
    input  logic signed [lcdm_pkg::SAMPLE_W-1:0]  x_a,
    input  logic signed [lcdm_pkg::SAMPLE_W-1:0]  x_b,
    input  logic signed [lcdm_pkg::SAMPLE_W-1:0]  y_a,
    input  logic signed [lcdm_pkg::SAMPLE_W-1:0]  y_b,
    output logic signed [lcdm_pkg::SUM_W-1:0]     sum,
    output logic                                  busy
);

    logic                                 rd_vld_reg;
    logic                                 diff_vld_reg;
    logic                                 prod_vld_reg;
    logic signed [lcdm_pkg::DIFF_W-1:0]   dx_reg, dx_next;
    logic signed [lcdm_pkg::DIFF_W-1:0]   dy_reg, dy_next;
    logic signed [lcdm_pkg::PROD_W-1:0]   prod_reg, prod_next;
    logic signed [lcdm_pkg::SUM_W-1:0]    acc_reg, acc_next;

    assign dx_next   = $signed({x_b[lcdm_pkg::SAMPLE_W-1], x_b})
                     - $signed({x_a[lcdm_pkg::SAMPLE_W-1], x_a});
    assign dy_next   = $signed({y_b[lcdm_pkg::SAMPLE_W-1], y_b})
                     - $signed({y_a[lcdm_pkg::SAMPLE_W-1], y_a});
    assign prod_next = dx_reg * dy_reg;
    assign acc_next  = acc_reg + $signed({{(lcdm_pkg::SUM_W - lcdm_pkg::PROD_W)
                                           {prod_reg[lcdm_pkg::PROD_W-1]}}, prod_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_vld_reg   <= 1'b0;
            diff_vld_reg <= 1'b0;
            prod_vld_reg <= 1'b0;
        end else begin
            rd_vld_reg   <= ctl.issue;
            diff_vld_reg <= rd_vld_reg;
            prod_vld_reg <= diff_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        dx_reg   <= dx_next;
        dy_reg   <= dy_next;
        prod_reg <= prod_next;
        if (ctl.clr) begin
            acc_reg <= '0;
        end else if (prod_vld_reg) begin
            acc_reg <= acc_next;
        end
    end

    assign sum  = acc_reg;
    assign busy = rd_vld_reg | diff_vld_reg | prod_vld_reg;

endmodule

// ===== rtl/lcdm_div.sv =====
// lcdm_div: bit-serial signed divider, quotient truncated toward zero,
// one quotient bit per cycle
// depends on lcdm_pkg
module lcdm_div (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  start,
    input  logic signed [lcdm_pkg::SUM_W-1:0]     dividend,
    input  logic [lcdm_pkg::DIVISOR_W-1:0]        divisor,
    output logic signed [lcdm_pkg::SUM_W-1:0]     quotient,
    output lcdm_pkg::div_stat_t                   stat
);

    logic                                 busy_reg;
    logic                                 done_reg;
    logic                                 neg_reg;
    logic [lcdm_pkg::STEP_W-1:0]          step_reg;
    logic [lcdm_pkg::DIVISOR_W-1:0]       dvs_reg;
    logic [lcdm_pkg::DIVISOR_W-1:0]       rem_reg, rem_next;
    logic [lcdm_pkg::SUM_W-1:0]           quo_reg, quo_next;
    logic [lcdm_pkg::DIVISOR_W:0]         trial;
    logic                                 qbit;

    assign trial    = {rem_reg, quo_reg[lcdm_pkg::SUM_W-1]};
    assign qbit     = (trial >= {1'b0, dvs_reg});
    assign rem_next = qbit ? lcdm_pkg::DIVISOR_W'(trial - {1'b0, dvs_reg})
                           : trial[lcdm_pkg::DIVISOR_W-1:0];
    assign quo_next = {quo_reg[lcdm_pkg::SUM_W-2:0], qbit};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && step_reg == '0) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            neg_reg  <= dividend[lcdm_pkg::SUM_W-1];
            quo_reg  <= dividend[lcdm_pkg::SUM_W-1] ? -dividend : dividend;
            rem_reg  <= '0;
            dvs_reg  <= divisor;
            step_reg <= lcdm_pkg::STEP_W'(lcdm_pkg::DIV_STEPS - 1);
        end else if (busy_reg) begin
            quo_reg  <= quo_next;
            rem_reg  <= rem_next;
            step_reg <= step_reg - 1'b1;
        end
    end

    assign quotient  = neg_reg ? -$signed(quo_reg) : $signed(quo_reg);
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

// ===== rtl/lagged_cross_displacement_mean.sv =====
// lagged_cross_displacement_mean: top level, sample loading, lag sequencer
// and result register
// depends on lcdm_pkg, lcdm_store, lcdm_mac, lcdm_div
//
// Paired Q8.16 samples are taken one per cycle into two 64-entry memories
// until an item with s_tlast set closes the set of N samples (samples past
// the 64th are dropped, a final one still starts the run). The block then
// drops s_tready and, for each lag d from 1 to N-1, streams the N-d sample
// pairs through the two memory read ports into one difference-multiply-
// accumulate pipeline, one pair per cycle, then divides the sum by N-d in a
// bit-serial divider. Each lag waits for m_tready before the next starts;
// one result is shown per lag in rising lag order, with m_tlast on the
// largest lag, and s_tready returns once that result is taken. A set of
// one sample gives no result.
module lagged_cross_displacement_mean (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [lcdm_pkg::S_TDATA_W-1:0]     s_tdata,   // sample_x, sample_y
    input  logic                               s_tlast,   // final_sample
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [lcdm_pkg::M_TDATA_W-1:0]     m_tdata,   // lag, mean_product, zero pad
    output logic                               m_tlast    // run_end
);

    typedef enum logic [5:0] {
        S_LOAD  = 6'b000001,
        S_START = 6'b000010,
        S_ISSUE = 6'b000100,
        S_DRAIN = 6'b001000,
        S_DIV   = 6'b010000,
        S_EMIT  = 6'b100000
    } state_t;

    state_t                              state_reg, state_next;
    logic [lcdm_pkg::CNT_W-1:0]          cnt_reg, cnt_next;
    logic [lcdm_pkg::CNT_W-1:0]          n_reg, n_next;
    logic [lcdm_pkg::LAG_W-1:0]          lag_reg, lag_next;
    logic [lcdm_pkg::ADDR_W-1:0]         idx_reg, idx_next;
    logic                                m_tvalid_reg, m_tvalid_next;
    logic                                m_tlast_reg;
    logic signed [lcdm_pkg::SUM_W-1:0]   mean_reg;
    logic [lcdm_pkg::LAG_W-1:0]          lag_out_reg;

    logic                                s_acc;
    logic                                room;
    logic [lcdm_pkg::CNT_W-1:0]          n_calc;
    logic                                last_pair;
    logic                                last_lag;
    logic                                div_start;
    logic [lcdm_pkg::DIVISOR_W-1:0]      divisor;

    lcdm_pkg::mac_ctl_t                  mac_ctl;
    lcdm_pkg::div_stat_t                 div_stat;
    logic                                mac_busy;
    logic signed [lcdm_pkg::SUM_W-1:0]   mac_sum;
    logic signed [lcdm_pkg::SUM_W-1:0]   quotient;
    logic signed [lcdm_pkg::SAMPLE_W-1:0] x_a, x_b, y_a, y_b;
    logic [lcdm_pkg::ADDR_W-1:0]         rd_addr_b;

    assign s_tready  = (state_reg == S_LOAD);
    assign s_acc     = s_tvalid && s_tready;
    assign room      = (cnt_reg < lcdm_pkg::CNT_W'(lcdm_pkg::MAX_SAMPLES));
    assign n_calc    = cnt_reg + lcdm_pkg::CNT_W'(room);
    assign rd_addr_b = idx_reg + lag_reg;
    assign last_pair = (({1'b0, idx_reg} + {1'b0, lag_reg}) == (n_reg - 1'b1));
    assign last_lag  = ({1'b0, lag_reg} == (n_reg - 1'b1));
    assign divisor   = n_reg - {1'b0, lag_reg};

    assign mac_ctl.clr   = (state_reg == S_START);
    assign mac_ctl.issue = (state_reg == S_ISSUE);
    assign div_start     = (state_reg == S_DRAIN) && !mac_busy && !div_stat.busy;

    lcdm_store u_store (
        .aclk      (aclk),
        .wr_en     (s_acc && room),
        .wr_addr   (cnt_reg[lcdm_pkg::ADDR_W-1:0]),
        .wr_x      (s_tdata[lcdm_pkg::SAMPLE_W-1:0]),
        .wr_y      (s_tdata[lcdm_pkg::S_TDATA_W-1:lcdm_pkg::SAMPLE_W]),
        .rd_addr_a (idx_reg),
        .rd_addr_b (rd_addr_b),
        .x_a       (x_a),
        .x_b       (x_b),
        .y_a       (y_a),
        .y_b       (y_b)
    );

    lcdm_mac u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (mac_ctl),
        .x_a     (x_a),
        .x_b     (x_b),
        .y_a     (y_a),
        .y_b     (y_b),
        .sum     (mac_sum),
        .busy    (mac_busy)
    );

    lcdm_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (mac_sum),
        .divisor  (divisor),
        .quotient (quotient),
        .stat     (div_stat)
    );

    always_comb begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        n_next        = n_reg;
        lag_next      = lag_reg;
        idx_next      = idx_reg;
        m_tvalid_next = m_tvalid_reg;
        case (state_reg)
            S_LOAD: begin
                if (s_acc) begin
                    if (s_tlast) begin
                        cnt_next = '0;
                        n_next   = n_calc;
                        lag_next = lcdm_pkg::LAG_W'(1);
                        if (n_calc > lcdm_pkg::CNT_W'(1)) begin
                            state_next = S_START;
                        end
                    end else begin
                        cnt_next = n_calc;
                    end
                end
            end
            S_START: begin
                idx_next   = '0;
                state_next = S_ISSUE;
            end
            S_ISSUE: begin
                idx_next = idx_reg + 1'b1;
                if (last_pair) begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (div_start) begin
                    state_next = S_DIV;
                end
            end
            S_DIV: begin
                if (div_stat.done) begin
                    m_tvalid_next = 1'b1;
                    state_next    = S_EMIT;
                end
            end
            S_EMIT: begin
                if (m_tready) begin
                    m_tvalid_next = 1'b0;
                    if (m_tlast_reg) begin
                        state_next = S_LOAD;
                    end else begin
                        lag_next   = lag_reg + 1'b1;
                        state_next = S_START;
                    end
                end
            end
            default: begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_LOAD;
            cnt_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        n_reg   <= n_next;
        lag_reg <= lag_next;
        idx_reg <= idx_next;
        if (state_reg == S_DIV && div_stat.done) begin
            mean_reg    <= quotient;
            lag_out_reg <= lag_reg;
            m_tlast_reg <= last_lag;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tdata  = {{lcdm_pkg::M_PAD_W{1'b0}}, mean_reg, lag_out_reg};

endmodule

// ===== rtl/lcdm_checker.sv =====
// lcdm_checker: port-level assertions for the lagged cross displacement
// mean block, attached to the top level by bind
// depends on lcdm_pkg and lagged_cross_displacement_mean
module lcdm_checker (
    input logic                               aclk,
    input logic                               aresetn,
    input logic                               s_tvalid,
    input logic                               s_tready,
    input logic [lcdm_pkg::S_TDATA_W-1:0]     s_tdata,
    input logic                               s_tlast,
    input logic                               m_tvalid,
    input logic                               m_tready,
    input logic [lcdm_pkg::M_TDATA_W-1:0]     m_tdata,
    input logic                               m_tlast
);

    // loading and result delivery never overlap
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input ready while a result is shown");

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result changed");

    // a non-final item keeps the block loading
    a_keep_loading: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && !s_tlast |=> s_tready)
        else $error("ready dropped after a non-final item");

    // the end of a run hands back to loading
    a_run_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && m_tlast |=> s_tready && !m_tvalid)
        else $error("no return to loading after the last result");

    // lag is never zero and the pad bits stay clear
    a_lag_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[lcdm_pkg::LAG_W-1:0] != '0
                     && m_tdata[lcdm_pkg::M_TDATA_W-1:lcdm_pkg::LAG_W+lcdm_pkg::SUM_W] == '0)
        else $error("bad lag or pad bits in result");

endmodule

bind lagged_cross_displacement_mean lcdm_checker u_lcdm_checker (.*);
